// ===== hw/rtl/hlm_pkg.sv =====
// ============================================================================
// hlm_pkg: shared types and constants of the heartbeat liveness monitor
// Node table size, opcodes, event codes, register map and the command
// record that goes from the front end to the back end.
// ============================================================================
package hlm_pkg;

    // Table size and derived widths
    localparam int NODES     = 32;
    localparam int NODE_W    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int ACT_W     = $clog2(NODES + 1);
    localparam int EV_NODE_W = 5;
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 8;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Opcodes
    typedef logic [1:0] op_t;
    localparam op_t OP_TICK = 2'd0;
    localparam op_t OP_MSG  = 2'd1;
    localparam op_t OP_DEAD = 2'd2;
    localparam op_t OP_LOAD = 2'd3;

    // Event codes
    localparam logic EV_NEW  = 1'b0;
    localparam logic EV_LOST = 1'b1;

    // Register map (index = paddr[2])
    localparam logic REG_DEAD_LIMIT = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    localparam logic [7:0] DEAD_LIMIT_RST = 8'd10;
    localparam logic [5:0] NODE_COUNT_RST = 6'd32;
    localparam logic [CNT_W-1:0] MISS_MAX = 8'hFF;

    // Classified command
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic              addr_nz;
        logic [NODE_W-1:0] idx;
        logic              node_ok;   // node < NODES
        logic              close;     // close notice, else info
    } cmd_t;

    // Live configuration
    typedef struct packed {
        logic [7:0] dead_limit;
        logic [5:0] node_count;
    } cfg_t;

    function automatic logic [EV_NODE_W-1:0] to_ev_node(input logic [NODE_W-1:0] n);
        logic [31:0] w;
        begin
            w = 32'(n);
            return w[EV_NODE_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/hlm_front.sv =====
// ============================================================================
// hlm_front: input acceptance, classification and command queue
// Decodes each accepted item into a command record and holds it in a
// short FIFO until the back end pops it.
// ============================================================================
module hlm_front
    import hlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        op,
    input  logic [31:0]       src_addr,
    input  logic [7:0]        node,
    input  logic              msg_kind,
    output logic              head_valid,
    output cmd_t              head,
    input  logic              pop
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              cmd_in;
    logic              push;
    logic              do_pop;

    // classify
    always_comb
    begin
        cmd_in.op      = op;
        cmd_in.addr    = src_addr;
        cmd_in.addr_nz = |src_addr;
        cmd_in.idx     = node[NODE_W-1:0];
        cmd_in.node_ok = (32'(node) < NODES);
        cmd_in.close   = msg_kind;
    end

    assign item_stall = (32'(cnt_reg) == QDEPTH);
    assign push       = item_valid && !item_stall;
    assign head_valid = (cnt_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== hw/rtl/hlm_back.sv =====
// ============================================================================
// hlm_back: command execution and node state
// Holds the host address table and per-node liveness state, matches
// message addresses, walks the active nodes on a tick and drives the
// event output register.
// ============================================================================
module hlm_back
    import hlm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 head_valid,
    input  cmd_t                 head,
    output logic                 pop,
    output logic                 event_valid,
    input  logic                 event_stall,
    output logic                 event_kind,
    output logic [EV_NODE_W-1:0] event_node,
    output logic                 last_event
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [NODES-1:0]  match_reg, match_next;
    logic [NODE_W-1:0] idx_reg, idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0] pend_node_reg, pend_node_next;

    // node state
    logic [ADDR_W-1:0] host_addr_reg [NODES];
    logic [NODES-1:0]  host_valid_reg;
    logic [NODES-1:0]  up_reg;
    logic [NODES-1:0]  pinged_reg;
    logic [CNT_W-1:0]  miss_reg [NODES];

    // output register
    logic                 ev_valid_reg;
    logic                 ev_kind_reg;
    logic [EV_NODE_W-1:0] ev_node_reg;
    logic                 ev_last_reg;

    // write controls
    logic                 host_we;
    logic                 up_we, up_val;
    logic [NODE_W-1:0]    up_idx;
    logic                 miss_we;
    logic [NODE_W-1:0]    miss_idx;
    logic [CNT_W-1:0]     miss_val;
    logic                 ping_set, ping_clr_all;
    logic                 ev_load, ev_kind_d, ev_last_d;
    logic [EV_NODE_W-1:0] ev_node_d;

    logic [ACT_W-1:0]  act;
    logic              out_free;
    logic [NODES-1:0]  head_match;
    logic [NODES-1:0]  low_mask;
    logic              hit;
    logic              walk_last;
    logic [CNT_W-1:0]  cnt_cur, cnt_inc;
    logic              walk_lost;

    assign act = (32'(cfg.node_count) > NODES) ? ACT_W'(NODES) : ACT_W'(cfg.node_count);
    assign out_free = !ev_valid_reg || !event_stall;

    // parallel address compare
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            head_match[i] = host_valid_reg[i] && head.addr_nz && (host_addr_reg[i] == head.addr);
        end
    end

    // lowest match must be the claimed node
    assign low_mask = (NODES'(1) << cmd_reg.idx) - NODES'(1);
    assign hit = cmd_reg.node_ok && match_reg[cmd_reg.idx] && ((match_reg & low_mask) == '0);

    // tick walk
    assign walk_last = (32'(idx_reg) + 1 == 32'(act));
    assign cnt_cur   = miss_reg[idx_reg];
    assign cnt_inc   = (!pinged_reg[idx_reg] && cnt_cur != MISS_MAX) ? cnt_cur + 1'b1 : cnt_cur;
    assign walk_lost = up_reg[idx_reg] && (cnt_inc > cfg.dead_limit);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        match_next      = match_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        pop             = 1'b0;
        host_we         = 1'b0;
        up_we           = 1'b0;
        up_val          = 1'b0;
        up_idx          = cmd_reg.idx;
        miss_we         = 1'b0;
        miss_idx        = cmd_reg.idx;
        miss_val        = '0;
        ping_set        = 1'b0;
        ping_clr_all    = 1'b0;
        ev_load         = 1'b0;
        ev_kind_d       = EV_LOST;
        ev_node_d       = to_ev_node(cmd_reg.idx);
        ev_last_d       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    case (head.op)
                        OP_TICK:
                        begin
                            idx_next   = '0;
                            state_next = (act == '0) ? ST_FLUSH : ST_WALK;
                        end
                        OP_MSG:
                        begin
                            match_next = head_match;
                            state_next = ST_DECIDE;
                        end
                        OP_DEAD:
                        begin
                            if (head.node_ok && (32'(head.idx) < 32'(act)))
                            begin
                                up_we  = 1'b1;
                                up_idx = head.idx;
                                up_val = 1'b0;
                            end
                        end
                        default:
                        begin
                            host_we = head.node_ok && head.addr_nz;
                        end
                    endcase
                end
            end

            ST_DECIDE:
            begin
                if (!hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (cmd_reg.close)
                begin
                    if (out_free)
                    begin
                        up_we      = 1'b1;
                        up_val     = 1'b0;
                        ev_load    = 1'b1;
                        ev_kind_d  = EV_LOST;
                        state_next = ST_IDLE;
                    end
                end
                else if (up_reg[cmd_reg.idx] || out_free)
                begin
                    miss_we    = 1'b1;
                    miss_val   = '0;
                    ping_set   = 1'b1;
                    up_we      = 1'b1;
                    up_val     = 1'b1;
                    ev_load    = !up_reg[cmd_reg.idx];
                    ev_kind_d  = EV_NEW;
                    state_next = ST_IDLE;
                end
            end

            ST_WALK:
            begin
                // a held lost event leaves with last clear once a newer one appears
                if (!(walk_lost && pend_valid_reg) || out_free)
                begin
                    miss_we  = up_reg[idx_reg];
                    miss_idx = idx_reg;
                    miss_val = cnt_inc;
                    if (walk_lost)
                    begin
                        up_we           = 1'b1;
                        up_idx          = idx_reg;
                        up_val          = 1'b0;
                        ev_load         = pend_valid_reg;
                        ev_kind_d       = EV_LOST;
                        ev_node_d       = to_ev_node(pend_node_reg);
                        ev_last_d       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_node_next  = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (walk_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    ev_load         = pend_valid_reg;
                    ev_kind_d       = EV_LOST;
                    ev_node_d       = to_ev_node(pend_node_reg);
                    ev_last_d       = 1'b1;
                    pend_valid_next = 1'b0;
                    ping_clr_all    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            ev_valid_reg   <= 1'b0;
            host_valid_reg <= '0;
            up_reg         <= '0;
            pinged_reg     <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                miss_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            if (ev_load)
            begin
                ev_valid_reg <= 1'b1;
            end
            else if (!event_stall)
            begin
                ev_valid_reg <= 1'b0;
            end
            if (host_we)
            begin
                host_valid_reg[cmd_next.idx] <= 1'b1;
            end
            if (up_we)
            begin
                up_reg[up_idx] <= up_val;
            end
            if (ping_clr_all)
            begin
                pinged_reg <= '0;
            end
            else if (ping_set)
            begin
                pinged_reg[cmd_reg.idx] <= 1'b1;
            end
            if (miss_we)
            begin
                miss_reg[miss_idx] <= miss_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        match_reg     <= match_next;
        idx_reg       <= idx_next;
        pend_node_reg <= pend_node_next;
        if (host_we)
        begin
            host_addr_reg[cmd_next.idx] <= cmd_next.addr;
        end
        if (ev_load)
        begin
            ev_kind_reg <= ev_kind_d;
            ev_node_reg <= ev_node_d;
            ev_last_reg <= ev_last_d;
        end
    end

    assign event_valid = ev_valid_reg;
    assign event_kind  = ev_kind_reg;
    assign event_node  = ev_node_reg;
    assign last_event  = ev_last_reg;

    // the walk index never passes the active count
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> 32'(idx_reg) < 32'(act))
        else $error("walk index beyond active nodes");

    // a held event exists only while a tick is in progress
    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_WALK || state_reg == ST_FLUSH))
        else $error("pending event outside tick");

    // finishing a tick clears every pinged bit and returns to idle
    a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && (!pend_valid_reg || out_free))
            |=> (pinged_reg == '0 && state_reg == ST_IDLE))
        else $error("tick end did not clear pinged bits");

    // commands are popped only when idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && head_valid))
        else $error("pop outside idle");

    // a loaded event never overwrites one still waiting at the output
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ev_load |-> out_free)
        else $error("event register overrun");

endmodule

// ===== hw/rtl/heartbeat_liveness_monitor_core.sv =====
// ============================================================================
// heartbeat_liveness_monitor_core: cluster node liveness tracker
// Each accepted item is one of: tick (timeout period), received heartbeat
// message, declare node dead, or load a node's host address. Items enter a
// two-entry command queue, so until it fills the input keeps flowing while
// the executing side works or waits on a stalled output. Load and
// declare-dead retire as they are popped. A message first has the parallel
// compare of its source address against all 32 table entries registered,
// then a check that the lowest match is the claimed node and an update of
// that node; a new or lost event, if any, is then placed in the output
// register. A tick walks the active nodes, min(node_count, 32) of them,
// one per cycle unless a lost event backs up at a stalled output. Every
// event carries last_event set on the final event of its item; items that
// cause no event produce no transfer. There is no clearing pass after
// reset. Registers: dead_limit at byte address 0 (reset 10), node_count at
// byte address 4 (reset 32); write them only while the block is idle.
// ============================================================================
module heartbeat_liveness_monitor_core
    import hlm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // item channel
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [1:0]           op,
    input  logic [31:0]          src_addr,
    input  logic [7:0]           node,
    input  logic                 msg_kind,

    // event channel
    output logic                 event_valid,
    input  logic                 event_stall,
    output logic                 event_kind,
    output logic [EV_NODE_W-1:0] event_node,
    output logic                 last_event,

    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [7:0] dead_limit_reg;
    logic [5:0] node_count_reg;
    cfg_t       cfg;
    logic       cfg_wr;
    logic       head_valid;
    cmd_t       head;
    logic       pop;

    // --------------------------------------------------------------------
    // Configuration registers. No wait states; index is paddr[2].
    // --------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_limit_reg <= DEAD_LIMIT_RST;
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_DEAD_LIMIT: dead_limit_reg <= pwdata[7:0];
                REG_NODE_COUNT: node_count_reg <= pwdata[5:0];
                default:        dead_limit_reg <= dead_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DEAD_LIMIT: prdata = 32'(dead_limit_reg);
            REG_NODE_COUNT: prdata = 32'(node_count_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.dead_limit = dead_limit_reg;
    assign cfg.node_count = node_count_reg;

    // --------------------------------------------------------------------
    // Front end: accept, classify, queue
    // --------------------------------------------------------------------
    hlm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .src_addr   (src_addr),
        .node       (node),
        .msg_kind   (msg_kind),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // --------------------------------------------------------------------
    // Back end: node table, tick walk, event output register
    // --------------------------------------------------------------------
    hlm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .event_node  (event_node),
        .last_event  (last_event)
    );

endmodule
